>>> hdl/svlc_pkg.sv
// ----------------------------------------------------------------------------
// svlc_pkg
// Shared widths, codes and control structs of the voice loop cursor.
// ----------------------------------------------------------------------------
`default_nettype none

package svlc_pkg;

    localparam int CUR_W          = 32;   // cursor register, fixed point
    localparam int START_W        = 31;   // start position field
    localparam int REG_W          = 19;   // length and loop bound registers
    localparam int STEP_W         = 20;   // pitch step register
    localparam int MODE_W         = 2;
    localparam int FRAC_OUT_W     = 12;   // fraction field of a result
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 20;
    localparam int FRAC_BITS_DEF  = 12;
    localparam int INDEX_BITS_DEF = 19;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(4096);

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FWD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PP   = 2'd2;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP       = 3'd4;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic adv;
        logic chk;
        logic fin;
        logic load_out;
    } t_ctrl_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic need_move;
        logic need_div;
        logic rem_done;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hdl/svlc_if.sv
// ----------------------------------------------------------------------------
// svlc_if
// Valid/ready channels of the voice loop cursor: tick items in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface svlc_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [svlc_pkg::START_W-1:0]   start_position;

    modport source (output valid, output command, output start_position, input ready);
    modport sink   (input valid, input command, input start_position, output ready);
endinterface

interface svlc_out_if #(
    parameter int INDEX_BITS = svlc_pkg::INDEX_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic                              active;
    logic [INDEX_BITS-1:0]             sample_index;
    logic [svlc_pkg::FRAC_OUT_W-1:0]   fraction;

    modport source (output valid, output active, output sample_index, output fraction,
                    input ready);
    modport sink   (input valid, input active, input sample_index, input fraction,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/svlc_rem.sv
// ----------------------------------------------------------------------------
// svlc_rem
// Iterative remainder unit, one restoring step per cycle, with a fast path
// when the dividend is already below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module svlc_rem #(
    parameter int W = 34
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_dividend,
    input  wire logic [W-1:0] i_divisor,
    output logic              o_done,
    output logic [W-1:0]      o_remainder
);
    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic             r_first;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_dvd;
    logic [W-1:0]     r_div;
    logic [W-1:0]     r_rem;

    logic [W:0]       w_trial;
    logic [W:0]       w_sub;
    logic [W-1:0]     w_rem_next;

    assign w_trial    = {r_rem, r_dvd[W-1]};
    assign w_sub      = w_trial - {1'b0, r_div};
    assign w_rem_next = w_sub[W] ? w_trial[W-1:0] : w_sub[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_first <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_first <= 1'b1;
            end else if (r_busy) begin
                if (r_first) begin
                    r_first <= 1'b0;
                    if (r_dvd < r_div) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_cnt <= CNT_W'(W);
        end else if (r_busy) begin
            if (r_first) begin
                if (r_dvd < r_div) begin
                    r_rem <= r_dvd;
                end
            end else begin
                r_rem <= w_rem_next;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

>>> hdl/svlc_ctrl.sv
// ----------------------------------------------------------------------------
// svlc_ctrl
// Sequencer of the voice loop cursor: steps one tick through advance, bound
// check, optional remainder pass and final update, and owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module svlc_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    input  wire svlc_pkg::t_dp_sts   i_sts,
    output svlc_pkg::t_ctrl_cmd      o_cmd
);
    import svlc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADV  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_PUT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       w_acc;
    logic       w_out_free;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_cmd.accept   = w_acc;
    assign o_cmd.adv      = (r_state == ST_ADV);
    assign o_cmd.chk      = (r_state == ST_CHK);
    assign o_cmd.fin      = (r_state == ST_FIN);
    assign o_cmd.load_out = (r_state == ST_PUT) && w_out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_state = i_sts.need_move ? ST_ADV : ST_PUT;
                end
            end
            ST_ADV: begin
                n_state = ST_CHK;
            end
            ST_CHK: begin
                n_state = i_sts.need_div ? ST_DIV : ST_PUT;
            end
            ST_DIV: begin
                if (i_sts.rem_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state = ST_PUT;
            end
            ST_PUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> hdl/svlc_dp.sv
// ----------------------------------------------------------------------------
// svlc_dp
// Datapath of the voice loop cursor: configuration, cursor state, the step
// adder, bound checks, wrap and reflect arithmetic and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module svlc_dp #(
    parameter int FRAC_BITS  = svlc_pkg::FRAC_BITS_DEF,
    parameter int INDEX_BITS = svlc_pkg::INDEX_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [svlc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [svlc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire svlc_pkg::t_ctrl_cmd                i_cmd,
    output svlc_pkg::t_dp_sts                       o_sts,
    input  wire logic                               i_command,
    input  wire logic [svlc_pkg::START_W-1:0]       i_start_position,
    output logic                                    o_active,
    output logic [INDEX_BITS-1:0]                   o_sample_index,
    output logic [svlc_pkg::FRAC_OUT_W-1:0]         o_fraction
);
    import svlc_pkg::*;

    localparam int BND_W = REG_W + FRAC_BITS;
    localparam int WRK_W = ((CUR_W > BND_W) ? CUR_W : BND_W) + 2;

    localparam logic [1:0] KIND_WRAP = 2'd0;  // forward loop wrap
    localparam logic [1:0] KIND_PF   = 2'd1;  // ping-pong, hit end moving forward
    localparam logic [1:0] KIND_PB   = 2'd2;  // ping-pong, fell below start

    localparam logic signed [WRK_W-1:0] K_ONE = WRK_W'(1);

    logic [MODE_W-1:0]          r_mode;
    logic [REG_W-1:0]           r_slen;
    logic [REG_W-1:0]           r_lstart;
    logic [REG_W-1:0]           r_lend;
    logic [STEP_W-1:0]          r_step;

    logic [CUR_W-1:0]           r_cur;
    logic                       r_bwd;
    logic                       r_play;
    logic signed [WRK_W-1:0]    r_work;
    logic [1:0]                 r_kind;

    logic                       r_res_active;
    logic [INDEX_BITS-1:0]      r_res_index;
    logic [FRAC_OUT_W-1:0]      r_res_frac;
    logic                       r_out_active;
    logic [INDEX_BITS-1:0]      r_out_index;
    logic [FRAC_OUT_W-1:0]      r_out_frac;

    logic signed [WRK_W-1:0]    w_len;
    logic signed [WRK_W-1:0]    w_s;
    logic signed [WRK_W-1:0]    w_e;
    logic signed [WRK_W-1:0]    w_span;
    logic signed [WRK_W-1:0]    w_cur_ext;
    logic signed [WRK_W-1:0]    w_step_ext;
    logic                       w_is_fwd;
    logic                       w_is_pp;
    logic                       w_loop;
    logic                       w_empty;
    logic                       w_need_move;
    logic [CUR_W+INDEX_BITS-1:0] w_cur_wide;
    logic [CUR_W-1:0]           w_cur_frac;
    logic                       w_bwd_eff;
    logic                       w_c_ge_e;
    logic                       w_c_lt_s;
    logic signed [WRK_W-1:0]    w_c_clamp;
    logic                       w_need_div;
    logic [1:0]                 w_kind;
    logic signed [WRK_W-1:0]    w_dvd_s;
    logic [WRK_W-1:0]           w_divisor;
    logic                       w_rem_done;
    logic [WRK_W-1:0]           w_remainder;
    logic signed [WRK_W-1:0]    w_r;
    logic signed [WRK_W-1:0]    w_fin_c;
    logic                       w_fin_bwd;

    // bounds in fixed point
    assign w_len      = WRK_W'({r_slen, {FRAC_BITS{1'b0}}});
    assign w_s        = WRK_W'({r_lstart, {FRAC_BITS{1'b0}}});
    assign w_e        = WRK_W'({r_lend, {FRAC_BITS{1'b0}}});
    assign w_span     = w_e - w_s;
    assign w_cur_ext  = WRK_W'(r_cur);
    assign w_step_ext = WRK_W'(r_step);

    assign w_is_fwd = (r_mode == MODE_FWD);
    assign w_is_pp  = (r_mode == MODE_PP);
    assign w_loop   = w_is_fwd || w_is_pp;
    assign w_empty  = (w_e <= w_s);

    // a tick moves the cursor unless the voice is stopped or, with no loop, at or past its end
    assign w_need_move = (i_command == CMD_TICK) && r_play
                         && !(!w_loop && (w_cur_ext >= w_len));

    assign w_cur_wide = {{INDEX_BITS{1'b0}}, r_cur};
    assign w_cur_frac = r_cur & ~({CUR_W{1'b1}} << FRAC_BITS);

    assign w_bwd_eff = r_bwd && w_is_pp && !w_empty;

    // bound check on the moved cursor
    assign w_c_ge_e  = (r_work >= w_e);
    assign w_c_lt_s  = (r_work < w_s);
    assign w_c_clamp = r_work[WRK_W-1] ? '0 : r_work;

    assign w_need_div = w_loop && !w_empty
                        && (w_is_fwd ? w_c_ge_e : (r_bwd ? w_c_lt_s : w_c_ge_e));
    assign w_kind     = w_is_fwd ? KIND_WRAP : (r_bwd ? KIND_PB : KIND_PF);
    assign w_dvd_s    = (w_is_pp && r_bwd) ? (w_s - K_ONE - r_work) : (r_work - w_e);
    // ping-pong repeats every two loop lengths
    assign w_divisor  = w_is_fwd ? $unsigned(w_span) : $unsigned(w_span <<< 1);

    svlc_rem #(
        .W (WRK_W)
    ) u_rem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.chk && w_need_div),
        .i_dividend  ($unsigned(w_dvd_s)),
        .i_divisor   (w_divisor),
        .o_done      (w_rem_done),
        .o_remainder (w_remainder)
    );

    // place the cursor from the remainder of the overshoot
    assign w_r = $signed(w_remainder);

    always_comb begin
        w_fin_c   = w_s + w_r;
        w_fin_bwd = 1'b0;
        unique case (r_kind)
            KIND_WRAP: begin
                w_fin_c   = w_s + w_r;
                w_fin_bwd = 1'b0;
            end
            KIND_PF: begin
                if ((w_r == '0) && (r_work > w_e)) begin
                    // whole periods past the end come to rest on the loop end
                    w_fin_c   = w_e;
                    w_fin_bwd = 1'b0;
                end else if (w_r < w_span) begin
                    w_fin_c   = w_e - K_ONE - w_r;
                    w_fin_bwd = 1'b1;
                end else begin
                    w_fin_c   = w_s + w_r - w_span;
                    w_fin_bwd = 1'b0;
                end
            end
            KIND_PB: begin
                if (w_r <= w_span) begin
                    w_fin_c   = w_s + w_r;
                    w_fin_bwd = 1'b0;
                end else begin
                    w_fin_c   = w_e + w_span - K_ONE - w_r;
                    w_fin_bwd = 1'b1;
                end
            end
            default: begin
                w_fin_c   = w_s + w_r;
                w_fin_bwd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NONE;
            r_slen   <= '0;
            r_lstart <= '0;
            r_lend   <= '0;
            r_step   <= STEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LOOP_MODE:  r_mode   <= i_cfg_data[MODE_W-1:0];
                REG_SAMPLE_LEN: r_slen   <= i_cfg_data[REG_W-1:0];
                REG_LOOP_START: r_lstart <= i_cfg_data[REG_W-1:0];
                REG_LOOP_END:   r_lend   <= i_cfg_data[REG_W-1:0];
                REG_STEP:       r_step   <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur  <= '0;
            r_bwd  <= 1'b0;
            r_play <= 1'b0;
        end else if (i_cmd.accept) begin
            if (i_command == CMD_START) begin
                r_cur  <= CUR_W'(i_start_position);
                r_bwd  <= 1'b0;
                r_play <= 1'b1;
            end else if (!w_need_move) begin
                r_play <= 1'b0;
            end
        end else if (i_cmd.adv) begin
            r_bwd <= w_bwd_eff;
        end else if (i_cmd.chk) begin
            if (!w_need_div) begin
                if (w_loop && w_empty) begin
                    r_cur <= CUR_W'(w_c_clamp);
                    if (w_c_clamp >= w_e) begin
                        r_play <= 1'b0;
                    end
                end else if (w_loop) begin
                    r_cur <= CUR_W'(r_work);
                end else begin
                    r_cur <= CUR_W'(r_work);
                    if (r_work >= w_len) begin
                        r_play <= 1'b0;
                    end
                end
            end
        end else if (i_cmd.fin) begin
            r_cur <= CUR_W'(w_fin_c);
            r_bwd <= w_fin_bwd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res_active <= w_need_move;
            r_res_index  <= w_need_move ? w_cur_wide[FRAC_BITS +: INDEX_BITS] : '0;
            r_res_frac   <= w_need_move ? w_cur_frac[FRAC_OUT_W-1:0] : '0;
        end
        if (i_cmd.adv) begin
            r_work <= w_bwd_eff ? (w_cur_ext - w_step_ext) : (w_cur_ext + w_step_ext);
        end
        if (i_cmd.chk) begin
            r_kind <= w_kind;
        end
        if (i_cmd.load_out) begin
            r_out_active <= r_res_active;
            r_out_index  <= r_res_index;
            r_out_frac   <= r_res_frac;
        end
    end

    assign o_sts.need_move = w_need_move;
    assign o_sts.need_div  = w_need_div;
    assign o_sts.rem_done  = w_rem_done;

    assign o_active       = r_out_active;
    assign o_sample_index = r_out_index;
    assign o_fraction     = r_out_frac;

endmodule

`default_nettype wire

>>> hdl/sample_voice_loop_cursor.sv
// ----------------------------------------------------------------------------
// sample_voice_loop_cursor
// Loop-aware sample address generator for one voice of a sample mixer.
// ----------------------------------------------------------------------------
// Each tick transfer returns the sample index and fraction of the cursor as it
// stood, then moves the cursor by the step and applies the loop mode: stop at
// the sample end, wrap by the loop length, or reflect between the loop bounds.
// A start transfer places the cursor and returns an inactive result, as does a
// tick on a stopped voice. One item is worked on at a time; the next is taken
// while the previous result still waits in the output register. A start or a
// silent tick goes straight to the result register, a tick that stays inside
// its bounds passes the advance and bound-check states first, and a tick that
// wraps or reflects also passes the remainder and final-update states; there
// an overshoot shorter than one loop period (the loop length, twice that for
// ping-pong) takes the fast path of the bit-serial remainder unit, W bits
// wide (34 at default fraction width), that folds overshoots into the loop.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_voice_loop_cursor #(
    parameter int FRAC_BITS  = svlc_pkg::FRAC_BITS_DEF,
    parameter int INDEX_BITS = svlc_pkg::INDEX_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    svlc_in_if.sink                                i_item,
    svlc_out_if.source                             o_result,
    input  wire logic                              i_cfg_we,
    input  wire logic [svlc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [svlc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import svlc_pkg::*;

    t_ctrl_cmd              w_cmd;
    t_dp_sts                w_sts;
    logic                   w_in_ready;
    logic                   w_out_valid;
    logic                   w_active;
    logic [INDEX_BITS-1:0]  w_index;
    logic [FRAC_OUT_W-1:0]  w_frac;

    svlc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_result.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    svlc_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_command        (i_item.command),
        .i_start_position (i_item.start_position),
        .o_active         (w_active),
        .o_sample_index   (w_index),
        .o_fraction       (w_frac)
    );

    assign i_item.ready          = w_in_ready;
    assign o_result.valid        = w_out_valid;
    assign o_result.active       = w_active;
    assign o_result.sample_index = w_index;
    assign o_result.fraction     = w_frac;

    // one item in flight: no second transfer right after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("input taken while an item is in flight");

    // the remainder unit only reports while an item is being worked on
    a_rem_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.rem_done |-> !i_item.ready)
        else $error("remainder done with no item in flight");

    // a result appears only after the sequencer hands it over
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(w_cmd.load_out))
        else $error("result valid without a load");

endmodule

`default_nettype wire

>>> sim/tb_sample_voice_loop_cursor.sv
// ----------------------------------------------------------------------------
// tb_sample_voice_loop_cursor
// Self-checking bench for the loop-aware voice cursor.
// ----------------------------------------------------------------------------
// Drives start and tick transfers in random bursts across many register
// settings (no loop, forward loop, ping-pong, the unused mode, empty loop
// regions, extreme bounds and steps), predicts the sample index, fraction and
// active flag of every transfer, and checks each result in order while the
// result side stalls on its own pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sample_voice_loop_cursor;

    timeunit 1ns;
    timeprecision 1ps;

    import svlc_pkg::*;

    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int IDX_W        = INDEX_BITS_DEF;
    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    // mode code with no loop behavior of its own
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic             active;
        logic [IDX_W-1:0] sample_index;
        logic [11:0]      fraction;
    } t_fetch;

    // ------------------------------------------------------------------------
    // cursor predictor and ordered store of expected fetches
    // ------------------------------------------------------------------------
    class cursor_scoreboard;
        logic [MODE_W-1:0] mode;
        logic [REG_W-1:0]  len_r;
        logic [REG_W-1:0]  lstart;
        logic [REG_W-1:0]  lend;
        logic [STEP_W-1:0] step_r;
        logic [CUR_W-1:0]  cursor;
        bit                backward;
        bit                playing;
        t_fetch            pending_fetches[$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       active_seen;

        function new();
            mode     = MODE_NONE;
            len_r    = '0;
            lstart   = '0;
            lend     = '0;
            step_r   = STEP_RESET;
            cursor   = '0;
            backward = 0;
            playing  = 0;
            errors   = 0;
            checked  = 0;
            active_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LOOP_MODE:  mode   = data[MODE_W-1:0];
                REG_SAMPLE_LEN: len_r  = data[REG_W-1:0];
                REG_LOOP_START: lstart = data[REG_W-1:0];
                REG_LOOP_END:   lend   = data[REG_W-1:0];
                REG_STEP:       step_r = data[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function t_fetch advance_cursor(logic cmd, logic [START_W-1:0] pos);
            t_fetch  f;
            longint  c, lenf, sf, ef, span, k;
            bit      fwd, pp, again;
            f    = '0;
            fwd  = (mode == MODE_FWD);
            pp   = (mode == MODE_PP);
            lenf = longint'(len_r) << FRAC;
            sf   = longint'(lstart) << FRAC;
            ef   = longint'(lend) << FRAC;
            if (cmd == CMD_START) begin
                cursor   = {1'b0, pos};
                backward = 0;
                playing  = 1;
                return f;
            end
            if (!playing) return f;
            c = longint'(cursor);
            // no-loop voice already past its end goes silent
            if (!fwd && !pp && c >= lenf) begin
                playing = 0;
                return f;
            end
            f.active       = 1'b1;
            f.sample_index = cursor[FRAC +: IDX_W];
            f.fraction     = cursor[11:0];
            if (!pp || ef <= sf) backward = 0;
            if (backward) c = c - longint'(step_r);
            else c = c + longint'(step_r);
            if (fwd || pp) begin
                if (ef <= sf) begin
                    if (c < 0) c = 0;
                    if (c >= ef) playing = 0;
                end else if (fwd) begin
                    if (c >= ef) begin
                        span = ef - sf;
                        k    = (c - ef) / span + 1;
                        c    = c - k * span;
                    end
                end else if ((!backward && c >= ef) || (backward && c < sf)) begin
                    again = 1;
                    while (again) begin
                        if (!backward) c = 2 * ef - c - 1;
                        else c = 2 * sf - c - 1;
                        backward = !backward;
                        again = (c > ef || c < sf);
                    end
                end
            end else if (c >= lenf) begin
                playing = 0;
            end
            cursor = c[CUR_W-1:0];
            return f;
        endfunction

        function void note_item(logic cmd, logic [START_W-1:0] pos);
            pending_fetches.push_back(advance_cursor(cmd, pos));
        endfunction

        function void check_result(logic act, logic [IDX_W-1:0] idx, logic [11:0] frac);
            t_fetch want;
            if (pending_fetches.size() == 0) begin
                $error("result transfer with no expected fetch waiting");
                errors++;
                return;
            end
            want = pending_fetches.pop_front();
            checked++;
            if (want.active) active_seen++;
            if (act !== want.active) begin
                $error("active: expected %0d, actual %0d", want.active, act);
                errors++;
            end
            if (idx !== want.sample_index) begin
                $error("sample_index: expected %0d, actual %0d", want.sample_index, idx);
                errors++;
            end
            if (frac !== want.fraction) begin
                $error("fraction: expected %0d, actual %0d", want.fraction, frac);
                errors++;
            end
        endfunction

        function int pending_count();
            return pending_fetches.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, block
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    always #6 i_clk = ~i_clk;

    svlc_in_if  item_if ();
    svlc_out_if result_if ();

    sample_voice_loop_cursor i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_result   (result_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    cursor_scoreboard sb = new();

    int unsigned items_sent;
    int unsigned starts_sent;
    int unsigned settings_used;
    int unsigned cycle_count;
    int          hold_requests;
    int          holds_served;
    int          hold_left;
    int          stall_pct;
    int          span_left;

    initial begin
        i_rst_n                  = 1'b0;
        cfg_we                   = 1'b0;
        cfg_idx                  = '0;
        cfg_data                 = '0;
        item_if.valid            = 1'b0;
        item_if.command          = CMD_TICK;
        item_if.start_position   = '0;
        result_if.ready          = 1'b0;
        items_sent    = 0;
        starts_sent   = 0;
        settings_used = 0;
        cycle_count   = 0;
        hold_requests = 0;
        holds_served  = 0;
        hold_left     = 0;
        stall_pct     = 0;
        span_left     = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d fetches still expected",
                     cycle_count, sb.pending_count());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: check every transfer, stall on a pattern, honor hold-offs
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
            sb.check_result(result_if.active, result_if.sample_index, result_if.fraction);
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            result_if.ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served = holds_served + 1;
            hold_left    = HOLD_CYCLES;
            result_if.ready <= 1'b0;
        end else begin
            if (span_left == 0) begin
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 25;
                    3:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
                span_left = $urandom_range(100, 400);
            end
            span_left = span_left - 1;
            result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // sender tasks
    // ------------------------------------------------------------------------
    task automatic send_item(input logic cmd, input logic [START_W-1:0] pos);
        item_if.valid          <= 1'b1;
        item_if.command        <= cmd;
        item_if.start_position <= pos;
        do @(posedge i_clk); while (item_if.ready !== 1'b1);
        sb.note_item(cmd, pos);
        items_sent++;
        if (cmd == CMD_START) starts_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        item_if.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_count() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] m, input logic [CFG_DATA_W-1:0] len,
                             input logic [CFG_DATA_W-1:0] ls, input logic [CFG_DATA_W-1:0] le,
                             input logic [CFG_DATA_W-1:0] stp);
        logic [CFG_DATA_W-1:0] vals [5];
        logic [CFG_IDX_W-1:0]  idxs [5];
        wait_drained();
        vals = '{m, len, ls, le, stp};
        idxs = '{REG_LOOP_MODE, REG_SAMPLE_LEN, REG_LOOP_START, REG_LOOP_END, REG_STEP};
        for (int i = 0; i < 5; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idxs[i];
            cfg_data <= vals[i];
            @(posedge i_clk);
            sb.write_reg(idxs[i], vals[i]);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_bound();
        case ($urandom_range(0, 7))
            0:       return ($urandom_range(0, 1) != 0) ? CFG_DATA_W'(524287) : '0;
            1:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(0, 40));
        endcase
    endfunction

    task automatic random_setting();
        logic [CFG_DATA_W-1:0] m, len, ls, le, stp;
        int unsigned span;
        case ($urandom_range(0, 9))
            0, 1:       m = CFG_DATA_W'(MODE_NONE);
            2, 3, 4:    m = CFG_DATA_W'(MODE_FWD);
            5, 6, 7:    m = CFG_DATA_W'(MODE_PP);
            8:          m = CFG_DATA_W'(MODE_UNUSED);
            default:    m = CFG_DATA_W'($urandom);
        endcase
        len = pick_bound();
        ls  = pick_bound();
        if ($urandom_range(0, 5) == 0) le = pick_bound();
        else le = ls + CFG_DATA_W'($urandom_range(1, 24));
        span = (le[REG_W-1:0] > ls[REG_W-1:0]) ? 32'(le[REG_W-1:0] - ls[REG_W-1:0]) : 32'd1;
        if (span > 64) span = 64;
        case ($urandom_range(0, 7))
            0:       stp = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'(20'hFFFFF) : '0;
            1:       stp = CFG_DATA_W'($urandom);
            2:       stp = CFG_DATA_W'($urandom_range(0, (span * 4 + 1) << FRAC));
            default: stp = CFG_DATA_W'($urandom_range(1, 'h3000));
        endcase
        configure(m, len, ls, le, stp);
    endtask

    // a start lands mostly around the sample and loop region
    function automatic logic [START_W-1:0] pick_position();
        longint top;
        if ($urandom_range(0, 15) == 0) return START_W'($urandom);
        top = longint'((sb.len_r > sb.lend) ? sb.len_r : sb.lend);
        top = (top + 2) << FRAC;
        if (top > 64'h7FFFFFFF) top = 64'h7FFFFFFF;
        return START_W'($urandom_range(0, int'(top)));
    endfunction

    task automatic send_stream(input int n, input bit steady);
        int  burst_left, gap;
        bit  do_start;
        burst_left = $urandom_range(1, 24);
        for (int i = 0; i < n; i++) begin
            if (i == 0 || !sb.playing) do_start = ($urandom_range(0, 3) != 0);
            else do_start = ($urandom_range(0, 24) == 0);
            if (do_start) send_item(CMD_START, pick_position());
            else send_item(CMD_TICK, START_W'($urandom));
            burst_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0 || steady) ? 0 : $urandom_range(1, 8);
                if (gap > 0) pause_sender(gap);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int phase;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle voice, then a start far past an empty sample
        send_item(CMD_TICK, '0);
        send_item(CMD_START, 31'h7FFFFFFF);
        send_item(CMD_TICK, '0);
        send_item(CMD_TICK, 31'h7FFFFFFF);

        // no loop: the moved cursor reaches the sample end
        configure(CFG_DATA_W'(MODE_NONE), 20'd3, 20'd0, 20'd0, 20'h1800);
        send_item(CMD_START, '0);
        repeat (3) send_item(CMD_TICK, '0);

        // forward loop wraps by the loop length
        configure(CFG_DATA_W'(MODE_FWD), 20'd8, 20'd2, 20'd5, 20'h2800);
        send_item(CMD_START, 31'h4000);
        repeat (4) send_item(CMD_TICK, '0);

        // ping-pong reflects at both bounds
        configure(CFG_DATA_W'(MODE_PP), 20'd8, 20'd1, 20'd4, 20'h3000);
        send_item(CMD_START, 31'h1000);
        repeat (4) send_item(CMD_TICK, '0);

        // empty loop region stops the voice at the loop end
        configure(CFG_DATA_W'(MODE_PP), 20'd8, 20'd5, 20'd5, 20'h1000);
        send_item(CMD_START, 31'h3000);
        repeat (2) send_item(CMD_TICK, '0);

        // unused mode at the largest length and step
        configure(CFG_DATA_W'(MODE_UNUSED), 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        send_item(CMD_START, '0);
        repeat (2) send_item(CMD_TICK, '0);

        configure(CFG_DATA_W'(MODE_FWD), 20'd524287, 20'd0, 20'd524287, 20'hFFFFF);
        send_stream(20, 0);

        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            random_setting();
            if (phase == 5) begin
                // result side holds off while the sender keeps pushing
                hold_requests <= hold_requests + 1;
                send_stream(40, 1);
            end else if (phase == 10) begin
                send_stream(30, 0);
                wait_drained();
                send_stream(30, 0);
            end else begin
                send_stream($urandom_range(30, 90), 0);
            end
            phase++;
        end

        item_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_count() != 0);
        repeat (60) @(posedge i_clk);

        $display("covered %0d transfers (%0d starts) over %0d register settings",
                 items_sent, starts_sent, settings_used);
        $display("checked %0d results, %0d of them with the voice playing",
                 sb.checked, sb.active_seen);
        if (sb.errors == 0 && sb.pending_count() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
